[rtl/core/winograd_matrix_multiply_macros.svh]
// Assertion macros for the winograd_matrix_multiply checker.
// Each macro expects clk, and all but WMM_ASSERT_RESET expect rst_n, in the scope where it is used.
`ifndef WINOGRAD_MATRIX_MULTIPLY_MACROS_SVH
`define WINOGRAD_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication, masked during reset
`define WMM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define WMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define WMM_ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wmm_pkg.sv]
// Shared types and constants for the Winograd matrix multiply block.
// No dependencies; used by the interfaces, controller, datapath and checker.
package wmm_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  localparam int CMD_W     = 2;
  localparam int IDX_BITS  = 3;
  localparam int VALUE_W   = 16;
  localparam int PROD_W    = 64;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLUMNS  = 2'd2;

  typedef enum logic [1:0] {
    KIND_ROWF,
    KIND_COLF,
    KIND_CROSS,
    KIND_ODD
  } kind_t;

  // one multiply-accumulate term issued by the controller
  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic                first;
    logic                last;
    logic                fin;
    logic                zero;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic [IDX_BITS-1:0] idx0;
    logic [IDX_BITS-1:0] idx1;
  } term_t;

  // element write into the A or B store
  typedef struct packed {
    logic                we_a;
    logic                we_b;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic [VALUE_W-1:0]  value;
  } load_t;

endpackage

[rtl/core/wmm_if.sv]
// Channel interfaces: input items, result items and configuration writes.
// Depends on wmm_pkg for field widths.
interface wmm_in_if;
  logic                              valid;
  logic                              ready;
  logic [wmm_pkg::CMD_W-1:0]         command;
  logic [wmm_pkg::IDX_BITS-1:0]      row_index;
  logic [wmm_pkg::IDX_BITS-1:0]      col_index;
  logic signed [wmm_pkg::VALUE_W-1:0] value;
  modport source (output valid, command, row_index, col_index, value, input ready);
  modport sink   (input valid, command, row_index, col_index, value, output ready);
endinterface

interface wmm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wmm_pkg::PROD_W-1:0]  product;
  logic [wmm_pkg::IDX_BITS-1:0]       out_row;
  logic [wmm_pkg::IDX_BITS-1:0]       out_col;
  logic                               last;
  modport source (output valid, product, out_row, out_col, last, input ready);
  modport sink   (input valid, product, out_row, out_col, last, output ready);
endinterface

interface wmm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wmm_pkg::CFG_IDX_W-1:0] index;
  logic [wmm_pkg::DIM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/wmm_ctrl.sv]
// Controller: configuration registers, load decode and the term sequencer.
// Depends on wmm_pkg and the channel interfaces in wmm_if.sv.
module wmm_ctrl #(
  parameter int MAX_DIM = wmm_pkg::MAX_DIM_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  wmm_in_if.sink         in_ch,
  wmm_cfg_if.sink        cfg_ch,
  input  logic           adv,
  output wmm_pkg::term_t term,
  output wmm_pkg::load_t load
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = $clog2(MAX_DIM + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROWF,
    S_COLF,
    S_GAP,
    S_ELEM
  } state_t;

  state_t                     state_r;
  logic [wmm_pkg::DIM_W-1:0]  a_rows_r;
  logic [wmm_pkg::DIM_W-1:0]  inner_r;
  logic [wmm_pkg::DIM_W-1:0]  b_cols_r;
  logic [CNT_W-1:0]           rows_r;
  logic [CNT_W-1:0]           n_r;
  logic [CNT_W-1:0]           cols_r;
  logic [IDX_W-1:0]           k_r;
  logic [IDX_W-1:0]           j_r;
  logic [CNT_W-1:0]           i_r;

  logic             in_acc;
  logic             cfg_acc;
  logic             idx_ok;
  logic [CNT_W-1:0] half;
  logic [CNT_W-1:0] fterm;
  logic [CNT_W-1:0] eterm;
  logic             last_k;
  logic             last_j;
  logic             last_if;
  logic             last_ie;
  logic             odd_term;
  logic [CNT_W:0]   two_i;

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [wmm_pkg::DIM_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (int'(v) > MAX_DIM) return CNT_W'(MAX_DIM);
    return CNT_W'(v);
  endfunction

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign idx_ok       = (int'(in_ch.row_index) < MAX_DIM) && (int'(in_ch.col_index) < MAX_DIM);

  assign half     = n_r >> 1;
  assign fterm    = (half == '0) ? CNT_W'(1) : half;
  assign eterm    = half + CNT_W'(n_r[0]);
  assign last_k   = (CNT_W'(k_r) == rows_r - CNT_W'(1));
  assign last_j   = (CNT_W'(j_r) == cols_r - CNT_W'(1));
  assign last_if  = (i_r == fterm - CNT_W'(1));
  assign last_ie  = (i_r == eterm - CNT_W'(1));
  assign odd_term = n_r[0] && (i_r == half);
  assign two_i    = {i_r, 1'b0};

  always_comb begin
    load.we_a  = in_acc && idx_ok && (in_ch.command == wmm_pkg::CMD_LOAD_A);
    load.we_b  = in_acc && idx_ok && (in_ch.command == wmm_pkg::CMD_LOAD_B);
    load.row   = in_ch.row_index;
    load.col   = in_ch.col_index;
    load.value = in_ch.value;
  end

  always_comb begin
    term       = '0;
    term.row   = wmm_pkg::IDX_BITS'(k_r);
    term.col   = wmm_pkg::IDX_BITS'(j_r);
    term.idx0  = wmm_pkg::IDX_BITS'(two_i);
    term.idx1  = wmm_pkg::IDX_BITS'(two_i + (CNT_W+1)'(1));
    term.zero  = (half == '0);
    case (state_r)
      S_ROWF: begin
        term.valid = 1'b1;
        term.kind  = wmm_pkg::KIND_ROWF;
        term.first = (i_r == '0);
        term.last  = last_if;
        term.col   = '0;
      end
      S_COLF: begin
        term.valid = 1'b1;
        term.kind  = wmm_pkg::KIND_COLF;
        term.first = (i_r == '0);
        term.last  = last_if;
        term.row   = '0;
      end
      S_ELEM: begin
        term.valid = 1'b1;
        term.kind  = odd_term ? wmm_pkg::KIND_ODD : wmm_pkg::KIND_CROSS;
        term.first = (i_r == '0);
        term.last  = last_ie;
        term.fin   = last_ie && last_j && last_k;
        term.zero  = 1'b0;
        if (odd_term) begin
          term.idx0 = wmm_pkg::IDX_BITS'(n_r - CNT_W'(1));
        end
      end
      default: begin
        term.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      a_rows_r <= wmm_pkg::DIM_RESET;
      inner_r  <= wmm_pkg::DIM_RESET;
      b_cols_r <= wmm_pkg::DIM_RESET;
      rows_r   <= CNT_W'(1);
      n_r      <= CNT_W'(1);
      cols_r   <= CNT_W'(1);
      k_r      <= '0;
      j_r      <= '0;
      i_r      <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_ch.index)
          wmm_pkg::REG_A_ROWS:     a_rows_r <= cfg_ch.data;
          wmm_pkg::REG_INNER_SIZE: inner_r  <= cfg_ch.data;
          wmm_pkg::REG_B_COLUMNS:  b_cols_r <= cfg_ch.data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_ch.command == wmm_pkg::CMD_COMPUTE)) begin
            rows_r  <= clamp_dim(a_rows_r);
            n_r     <= clamp_dim(inner_r);
            cols_r  <= clamp_dim(b_cols_r);
            k_r     <= '0;
            j_r     <= '0;
            i_r     <= '0;
            state_r <= S_ROWF;
          end
        end
        S_ROWF: begin
          if (adv) begin
            if (last_if) begin
              i_r <= '0;
              if (last_k) begin
                k_r     <= '0;
                state_r <= S_COLF;
              end else begin
                k_r <= k_r + IDX_W'(1);
              end
            end else begin
              i_r <= i_r + CNT_W'(1);
            end
          end
        end
        S_COLF: begin
          if (adv) begin
            if (last_if) begin
              i_r <= '0;
              if (last_j) begin
                j_r     <= '0;
                state_r <= S_GAP;
              end else begin
                j_r <= j_r + IDX_W'(1);
              end
            end else begin
              i_r <= i_r + CNT_W'(1);
            end
          end
        end
        // a bubble state so the last column factor is written before it is read
        S_GAP: begin
          if (adv) begin
            state_r <= S_ELEM;
          end
        end
        S_ELEM: begin
          if (adv) begin
            if (last_ie) begin
              i_r <= '0;
              if (last_j) begin
                j_r <= '0;
                if (last_k) begin
                  k_r     <= '0;
                  state_r <= S_IDLE;
                end else begin
                  k_r <= k_r + IDX_W'(1);
                end
              end else begin
                j_r <= j_r + IDX_W'(1);
              end
            end else begin
              i_r <= i_r + CNT_W'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/wmm_dp.sv]
// Datapath: A/B element stores, factor registers and the
// read / multiply / accumulate pipeline feeding the output register.
// Depends on wmm_pkg and wmm_out_if in wmm_if.sv.
module wmm_dp #(
  parameter int MAX_DIM    = wmm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = wmm_pkg::ELEM_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  wmm_pkg::term_t term,
  input  wmm_pkg::load_t load,
  output logic           adv,
  wmm_out_if.source      out_ch
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OPW   = ELEM_WIDTH + 1;
  localparam int MULW  = 2 * ELEM_WIDTH + 2;
  localparam int PW    = wmm_pkg::PROD_W;

  logic [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic [ELEM_WIDTH-1:0] b_mem [DEPTH];
  logic [PW-1:0]         rf_r  [MAX_DIM];
  logic [PW-1:0]         cf_r  [MAX_DIM];

  logic [ELEM_WIDTH-1:0] wdata;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         ra0;
  logic [AW-1:0]         ra1;
  logic [AW-1:0]         rb0;
  logic [AW-1:0]         rb1;

  logic [ELEM_WIDTH-1:0] a0_r;
  logic [ELEM_WIDTH-1:0] a1_r;
  logic [ELEM_WIDTH-1:0] b0_r;
  logic [ELEM_WIDTH-1:0] b1_r;
  wmm_pkg::term_t        t1_r;

  logic signed [OPW-1:0]  op1;
  logic signed [OPW-1:0]  op2;
  logic signed [MULW-1:0] mul;
  logic [PW-1:0]          prod_r;
  logic [PW-1:0]          init_r;
  wmm_pkg::term_t         t2_r;

  logic [PW-1:0]               acc_r;
  logic [PW-1:0]               sum;
  logic                        elem2;
  logic                        emit;
  logic                        out_v_r;
  logic [PW-1:0]               product_r;
  logic [wmm_pkg::IDX_BITS-1:0] out_row_r;
  logic [wmm_pkg::IDX_BITS-1:0] out_col_r;
  logic                        out_last_r;

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  assign adv   = !out_v_r || out_ch.ready;
  assign wdata = ELEM_WIDTH'(signed'(load.value));
  assign waddr = addr_of(load.row[IDX_W-1:0], load.col[IDX_W-1:0]);
  assign ra0   = addr_of(term.row[IDX_W-1:0], term.idx0[IDX_W-1:0]);
  assign ra1   = addr_of(term.row[IDX_W-1:0], term.idx1[IDX_W-1:0]);
  assign rb0   = addr_of(term.idx0[IDX_W-1:0], term.col[IDX_W-1:0]);
  assign rb1   = addr_of(term.idx1[IDX_W-1:0], term.col[IDX_W-1:0]);

  // element stores, two registered read ports each
  always_ff @(posedge clk) begin
    if (load.we_a) begin
      a_mem[waddr] <= wdata;
    end
    if (load.we_b) begin
      b_mem[waddr] <= wdata;
    end
    if (adv) begin
      a0_r <= a_mem[ra0];
      a1_r <= a_mem[ra1];
      b0_r <= b_mem[rb0];
      b1_r <= b_mem[rb1];
    end
  end

  always_comb begin
    case (t1_r.kind)
      wmm_pkg::KIND_ROWF: begin
        op1 = OPW'(signed'(a0_r));
        op2 = OPW'(signed'(a1_r));
      end
      wmm_pkg::KIND_COLF: begin
        op1 = OPW'(signed'(b0_r));
        op2 = OPW'(signed'(b1_r));
      end
      wmm_pkg::KIND_CROSS: begin
        op1 = OPW'(signed'(a0_r)) + OPW'(signed'(b1_r));
        op2 = OPW'(signed'(a1_r)) + OPW'(signed'(b0_r));
      end
      default: begin
        op1 = OPW'(signed'(a0_r));
        op2 = OPW'(signed'(b0_r));
      end
    endcase
    // no pairs: both operands forced, the entries read may never have been loaded
    if (t1_r.zero) begin
      op1 = '0;
      op2 = '0;
    end
  end

  assign mul = op1 * op2;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= PW'(mul);
      if (t1_r.kind == wmm_pkg::KIND_CROSS || t1_r.kind == wmm_pkg::KIND_ODD) begin
        init_r <= PW'(0) - rf_r[t1_r.row[IDX_W-1:0]] - cf_r[t1_r.col[IDX_W-1:0]];
      end else begin
        init_r <= '0;
      end
    end
  end

  assign elem2 = (t2_r.kind == wmm_pkg::KIND_CROSS) || (t2_r.kind == wmm_pkg::KIND_ODD);
  assign sum   = (t2_r.first ? init_r : acc_r) + prod_r;
  assign emit  = t2_r.valid && t2_r.last && elem2;

  always_ff @(posedge clk) begin
    if (adv && t2_r.valid) begin
      acc_r <= sum;
      if (t2_r.last) begin
        case (t2_r.kind)
          wmm_pkg::KIND_ROWF: rf_r[t2_r.row[IDX_W-1:0]] <= sum;
          wmm_pkg::KIND_COLF: cf_r[t2_r.col[IDX_W-1:0]] <= sum;
          default: ;
        endcase
      end
    end
    if (adv && emit) begin
      product_r  <= sum;
      out_row_r  <= t2_r.row;
      out_col_r  <= t2_r.col;
      out_last_r <= t2_r.fin;
    end
  end

  // stage tags and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r    <= '0;
      t2_r    <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      t1_r    <= term;
      t2_r    <= t1_r;
      out_v_r <= emit;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.product = product_r;
  assign out_ch.out_row = out_row_r;
  assign out_ch.out_col = out_col_r;
  assign out_ch.last    = out_last_r;

endmodule

[rtl/core/winograd_matrix_multiply.sv]
// Load: elements are accepted while idle. Compute: F terms per row factor and per
// column factor, a gap, then E terms per element, F = max(n/2,1), E = n/2 + (n odd).
// Terms pass read and multiply registers: one term per cycle, one multiplier and one
// result per element. Output stalls freeze the whole pipeline. Synchronous active-low
// reset clears control, sets a_rows, inner_size, b_columns to 8; element stores undefined.
// Top level: joins wmm_ctrl and wmm_dp; depends on wmm_pkg and wmm_if.sv.
module winograd_matrix_multiply #(
  parameter int MAX_DIM    = wmm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = wmm_pkg::ELEM_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  wmm_in_if.sink    in_ch,
  wmm_out_if.source out_ch,
  wmm_cfg_if.sink   cfg_ch
);

  logic           adv;
  wmm_pkg::term_t term;
  wmm_pkg::load_t load;

  wmm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .adv    (adv),
    .term   (term),
    .load   (load)
  );

  wmm_dp #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .term   (term),
    .load   (load),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule

[rtl/core/wmm_checker.sv]
// Port-level checker for winograd_matrix_multiply, bound to the top level.
// Depends on wmm_pkg and winograd_matrix_multiply_macros.svh.
`include "winograd_matrix_multiply_macros.svh"

module wmm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [wmm_pkg::CMD_W-1:0]    in_command,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [wmm_pkg::PROD_W-1:0]   out_product,
  input logic                         out_last
);

  `WMM_ASSERT_RESET(a_no_result_after_reset, !rst_n, !out_valid, "result valid after reset")
  `WMM_ASSERT_NEXT(a_busy_after_compute, in_valid && in_ready && in_command == wmm_pkg::CMD_COMPUTE, !in_ready, "ready after compute transfer")
  `WMM_ASSERT_NEXT(a_ready_after_load, in_valid && in_ready && in_command != wmm_pkg::CMD_COMPUTE, in_ready, "not ready after load transfer")
  `WMM_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_product) && $stable(out_last), "stalled result changed")

endmodule

bind winograd_matrix_multiply wmm_checker u_wmm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_command  (in_ch.command),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_product (out_ch.product),
  .out_last    (out_ch.last)
);
